>>> src/frac_n_pll_divider_calc_assert.svh
// Assertion macros used by the divider back end.
`ifndef FRAC_N_PLL_DIVIDER_CALC_ASSERT_SVH
`define FRAC_N_PLL_DIVIDER_CALC_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define FNPLL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define FNPLL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define FNPLL_ASSERT(lbl, prop, msg)
`define FNPLL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/fnpll_pkg.sv
// Types and constants of the fractional-N divider calculation.
`timescale 1ns / 1ps
package fnpll_pkg;
    localparam int TargetW = 33;
    localparam int RefW    = 27;
    localparam int VcoW    = 39;

    localparam logic [TargetW-1:0] BAND0 = 33'd2200000000;
    localparam logic [TargetW-1:0] BAND1 = 33'd1100000000;
    localparam logic [TargetW-1:0] BAND2 = 33'd550000000;
    localparam logic [TargetW-1:0] BAND3 = 33'd275000000;
    localparam logic [TargetW-1:0] BAND4 = 33'd137500000;
    localparam logic [TargetW-1:0] BAND5 = 33'd68750000;
    localparam logic [VcoW-1:0]    VCO_MIN = 39'd2200000000;
    localparam logic [VcoW-1:0]    VCO_MAX = 39'd4400000000;

    localparam logic [15:0] MODULUS      = 16'd15625;
    localparam logic [14:0] MODULUS_X2   = 15'd31250;
    localparam logic [TargetW-1:0] PRESC_LIMIT = 33'd75;
    localparam logic [TargetW-1:0] INT_MIN_89  = 33'd23;
    localparam logic [RefW-1:0] REF_RESET = 27'd25000000;

    localparam logic [5:0] DIV1_STEPS = 6'd33;
    localparam logic [5:0] DIV2_STEPS = 6'd15;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic                err;
        logic [2:0]          code;
        logic [TargetW-1:0]  vco;
    } fnpll_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_EVAL,
        ST_MUL,
        ST_DIV2,
        ST_FIN
    } fnpll_state_t;
endpackage

>>> src/fnpll_front.sv
// Front end: accepts a target frequency, picks the output divider and checks the VCO range.
`timescale 1ns / 1ps
module fnpll_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fnpll_pkg::TargetW-1:0] target,
    output logic                         item_valid,
    input  logic                         item_ready,
    output fnpll_pkg::fnpll_item_t        item
);
    import fnpll_pkg::*;

    logic        valid_reg;
    fnpll_item_t item_reg;
    fnpll_item_t item_next;
    logic [VcoW-1:0] vco_wide;

    // Output divider from the frequency bands, then the VCO range check.
    always_comb begin
        if (target >= BAND0) begin
            item_next.code = 3'd0;
        end else if (target >= BAND1) begin
            item_next.code = 3'd1;
        end else if (target >= BAND2) begin
            item_next.code = 3'd2;
        end else if (target >= BAND3) begin
            item_next.code = 3'd3;
        end else if (target >= BAND4) begin
            item_next.code = 3'd4;
        end else if (target >= BAND5) begin
            item_next.code = 3'd5;
        end else begin
            item_next.code = 3'd6;
        end
        vco_wide = {6'd0, target} << item_next.code;
        item_next.err = (vco_wide < VCO_MIN) || (vco_wide > VCO_MAX);
        item_next.vco = vco_wide[TargetW-1:0];
    end

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Holding stage in front of the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end
endmodule

>>> src/fnpll_queue.sv
// Two-entry queue between the front end and the divider back end.
`timescale 1ns / 1ps
module fnpll_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fnpll_pkg::fnpll_item_t in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fnpll_pkg::fnpll_item_t out_item
);
    import fnpll_pkg::*;

    fnpll_item_t mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> src/fnpll_back.sv
// Back end: divides the VCO frequency by the reference and forms INT and FRAC.
`timescale 1ns / 1ps
module fnpll_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [fnpll_pkg::RefW-1:0]    reference_hz,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  fnpll_pkg::fnpll_item_t        item,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic                         status,
    output logic [2:0]                   out_div_code,
    output logic [15:0]                  int_value,
    output logic [13:0]                  frac_value,
    output logic                         prescaler_sel
);
    import fnpll_pkg::*;
`include "frac_n_pll_divider_calc_assert.svh"

    fnpll_state_t state_reg, state_next;
    logic [RefW-1:0]    ref_reg, ref_next;
    logic [RefW-1:0]    rem_reg, rem_next;
    logic [TargetW-1:0] dvd_reg, dvd_next;
    logic [TargetW-1:0] ratio_reg, ratio_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [2:0]         code_reg, code_next;
    logic               presc_reg, presc_next;

    logic               out_valid_reg, out_valid_next;
    logic               status_reg, status_next;
    logic [2:0]         div_code_reg, div_code_next;
    logic [15:0]        int_reg, int_next;
    logic [13:0]        frac_reg, frac_next;
    logic               psel_reg, psel_next;

    logic [RefW:0]      trial;
    logic               ge;
    logic [RefW:0]      diff;
    logic [41:0]        prod;
    logic [15:0]        frac_nearest;
    logic               out_free;

    // Restoring division step shared by both divisions, plus the MUL product and FRAC rounding.
    always_comb begin
        trial = {rem_reg, dvd_reg[TargetW-1]};
        ge    = (trial >= {1'b0, ref_reg});
        diff  = trial - {1'b0, ref_reg};
        prod  = {15'd0, rem_reg} * {27'd0, MODULUS_X2};
        frac_nearest = ({1'b0, dvd_reg[14:0]} + 16'd1) >> 1;
    end

    assign out_free   = !out_valid_reg || m_tready;
    assign item_ready = (state_reg == ST_IDLE) && out_free;

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        ref_next       = ref_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        ratio_next     = ratio_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        presc_next     = presc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        div_code_next  = div_code_reg;
        int_next       = int_reg;
        frac_next      = frac_reg;
        psel_next      = psel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (item_valid && out_free) begin
                    if (item.err) begin
                        out_valid_next = 1'b1;
                        status_next    = 1'b1;
                        div_code_next  = 3'd0;
                        int_next       = 16'd0;
                        frac_next      = 14'd0;
                        psel_next      = 1'b0;
                    end else begin
                        ref_next   = (reference_hz == '0) ? 27'd1 : reference_hz;
                        rem_next   = '0;
                        dvd_next   = item.vco;
                        code_next  = item.code;
                        cnt_next   = DIV1_STEPS;
                        state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1, ST_DIV2: begin
                rem_next = ge ? diff[RefW-1:0] : trial[RefW-1:0];
                dvd_next = {dvd_reg[TargetW-2:0], ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = (state_reg == ST_DIV1) ? ST_EVAL : ST_FIN;
                end
            end
            ST_EVAL: begin
                ratio_next = dvd_reg;
                presc_next = (dvd_reg < PRESC_LIMIT);
                if (dvd_reg < INT_MIN_89) begin
                    // Clamped ratio on the 8/9 prescaler: no fraction.
                    out_valid_next = 1'b1;
                    status_next    = 1'b0;
                    div_code_next  = code_reg;
                    int_next       = INT_MIN_89[15:0];
                    frac_next      = 14'd0;
                    psel_next      = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // Scaled remainder; its quotient by the reference fits 15 bits.
                rem_next   = prod[41:15];
                dvd_next   = {prod[14:0], 18'd0};
                cnt_next   = DIV2_STEPS;
                state_next = ST_DIV2;
            end
            ST_FIN: begin
                out_valid_next = 1'b1;
                status_next    = 1'b0;
                div_code_next  = code_reg;
                psel_next      = presc_reg;
                if (frac_nearest >= MODULUS) begin
                    frac_next = 14'd0;
                    int_next  = ratio_reg[15:0] + 16'd1;
                end else begin
                    frac_next = frac_nearest[13:0];
                    int_next  = ratio_reg[15:0];
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge aclk) begin
        ref_reg      <= ref_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        ratio_reg    <= ratio_next;
        cnt_reg      <= cnt_next;
        code_reg     <= code_next;
        presc_reg    <= presc_next;
        status_reg   <= status_next;
        div_code_reg <= div_code_next;
        int_reg      <= int_next;
        frac_reg     <= frac_next;
        psel_reg     <= psel_next;
    end

    assign m_tvalid      = out_valid_reg;
    assign status        = status_reg;
    assign out_div_code  = div_code_reg;
    assign int_value     = int_reg;
    assign frac_value    = frac_reg;
    assign prescaler_sel = psel_reg;

    // A new item is taken only with the sequencer idle.
    `FNPLL_ASSERT(a_pop_idle, (item_valid && item_ready) |-> (state_reg == ST_IDLE), "pop while busy")
    // Error results carry no settings.
    `FNPLL_ASSERT(a_err_zero, (out_valid_reg && status_reg) |-> (int_reg == 16'd0 && frac_reg == 14'd0 && !psel_reg && div_code_reg == 3'd0), "error result not cleared")
    // The fraction stays below the modulus.
    `FNPLL_ASSERT(a_frac_range, out_valid_reg |-> ({2'b0, frac_reg} < MODULUS), "fraction out of range")
    // While a calculation runs the result register is empty.
    `FNPLL_ASSERT(a_busy_empty, (state_reg != ST_IDLE) |-> !out_valid_reg, "result pending during calculation")
endmodule

>>> src/frac_n_pll_divider_calc.sv
// Valid items go through a bit-serial divider, 33 steps plus 15 unless clamped, one item at a time;
// error items skip the divider and pass one per cycle while results are taken at once.
// The front stage and a two-entry queue keep accepting while the divider is busy, until they are full.
// Reset: synchronous, active low; reference_hz returns to 25000000 and the front stage and the queue empty.
`timescale 1ns / 1ps
// Top level of the fractional-N divider calculation.
module frac_n_pll_divider_calc (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [26:0] cfg_wr_data,   // reference_hz
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // [32:0] target_hz, [39:33] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // [0] status, [3:1] out_div_code, [19:4] int_value,
                                       // [33:20] frac_value, [34] prescaler_sel, [39:35] zero
);
    import fnpll_pkg::*;

    logic [RefW-1:0] ref_reg;
    logic            f_valid, f_ready, q_valid, q_ready;
    fnpll_item_t     f_item, q_item;
    logic            status, psel;
    logic [2:0]      div_code;
    logic [15:0]     int_value;
    logic [13:0]     frac_value;

    // Reference frequency register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= REF_RESET;
        end else if (cfg_wr_en) begin
            ref_reg <= cfg_wr_data;
        end
    end

    fnpll_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .target(s_tdata[TargetW-1:0]),
        .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
    );

    fnpll_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    fnpll_back u_back (
        .aclk(aclk), .aresetn(aresetn), .reference_hz(ref_reg),
        .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .status(status), .out_div_code(div_code), .int_value(int_value),
        .frac_value(frac_value), .prescaler_sel(psel)
    );

    assign m_tdata = {5'd0, psel, frac_value, int_value, div_code, status};
endmodule
